// ===== hw/rtl/cmfs_pkg.sv =====
// ----------------------------------------------------------------------------
// cmfs_pkg: shared types for the cube map face select pipeline
// Face codes and the per-transaction control word that rides down the pipe.
// ----------------------------------------------------------------------------
package cmfs_pkg;

    localparam int FACE_BITS = 3;

    typedef enum logic [FACE_BITS-1:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } t_face;

    typedef struct packed {
        t_face face;
        logic  zero;
    } t_ctl;

endpackage

// ===== hw/rtl/cmfs_mag.sv =====
// ----------------------------------------------------------------------------
// cmfs_mag: component magnitude stage
// Registers the three signed components and their magnitudes.
// ----------------------------------------------------------------------------
module cmfs_mag #(
    parameter int COMP_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [COMP_BITS-1:0] i_x,
    input  logic signed [COMP_BITS-1:0] i_y,
    input  logic signed [COMP_BITS-1:0] i_z,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [COMP_BITS-1:0] o_x,
    output logic signed [COMP_BITS-1:0] o_y,
    output logic signed [COMP_BITS-1:0] o_z,
    output logic        [COMP_BITS-1:0] o_ax,
    output logic        [COMP_BITS-1:0] o_ay,
    output logic        [COMP_BITS-1:0] o_az
);

    logic                        r_valid;
    logic signed [COMP_BITS-1:0] r_x, r_y, r_z;
    logic        [COMP_BITS-1:0] r_ax, r_ay, r_az;
    logic        [COMP_BITS-1:0] n_ax, n_ay, n_az;
    logic                        w_load;

    // the most negative code negates to 2^(COMP_BITS-1), still exact unsigned
    always_comb begin
        n_ax = i_x[COMP_BITS-1] ? (~i_x + 1'b1) : i_x;
        n_ay = i_y[COMP_BITS-1] ? (~i_y + 1'b1) : i_y;
        n_az = i_z[COMP_BITS-1] ? (~i_z + 1'b1) : i_z;
    end

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_x  <= i_x;
            r_y  <= i_y;
            r_z  <= i_z;
            r_ax <= n_ax;
            r_ay <= n_ay;
            r_az <= n_az;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_ax    = r_ax;
    assign o_ay    = r_ay;
    assign o_az    = r_az;

endmodule

// ===== hw/rtl/cmfs_select.sv =====
// ----------------------------------------------------------------------------
// cmfs_select: major axis and face selection stage
// Picks the face, the largest magnitude and the two components feeding u, v.
// ----------------------------------------------------------------------------
module cmfs_select #(
    parameter int COMP_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [COMP_BITS-1:0] i_x,
    input  logic signed [COMP_BITS-1:0] i_y,
    input  logic signed [COMP_BITS-1:0] i_z,
    input  logic        [COMP_BITS-1:0] i_ax,
    input  logic        [COMP_BITS-1:0] i_ay,
    input  logic        [COMP_BITS-1:0] i_az,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic        [COMP_BITS-1:0] o_m,
    output logic signed [COMP_BITS-1:0] o_cu,
    output logic signed [COMP_BITS-1:0] o_cv,
    output logic                        o_sub_u,
    output logic                        o_sub_v,
    output cmfs_pkg::t_ctl              o_ctl
);

    logic                        r_valid;
    logic        [COMP_BITS-1:0] r_m, n_m;
    logic signed [COMP_BITS-1:0] r_cu, r_cv, n_cu, n_cv;
    logic                        r_sub_u, r_sub_v, n_sub_u, n_sub_v;
    cmfs_pkg::t_ctl              r_ctl, n_ctl;
    logic                        w_x_major, w_y_major, w_load;

    always_comb begin
        n_m = i_ax;
        if (i_ay > n_m) begin
            n_m = i_ay;
        end
        if (i_az > n_m) begin
            n_m = i_az;
        end
    end

    // strict wins only; ties fall through to the z faces
    assign w_x_major = (i_ax > i_ay) && (i_ax > i_az);
    assign w_y_major = (i_ay > i_ax) && (i_ay > i_az);

    always_comb begin
        n_ctl.zero = (n_m == '0);
        n_cu    = i_x;
        n_cv    = i_y;
        n_sub_u = 1'b0;
        n_sub_v = 1'b0;
        if (w_x_major) begin
            n_cu = i_z;
            if (!i_x[COMP_BITS-1]) begin
                n_ctl.face = cmfs_pkg::FACE_POS_X;
                n_sub_u    = 1'b1;
            end else begin
                n_ctl.face = cmfs_pkg::FACE_NEG_X;
            end
        end else if (w_y_major) begin
            n_cv = i_z;
            if (!i_y[COMP_BITS-1]) begin
                n_ctl.face = cmfs_pkg::FACE_POS_Y;
                n_sub_v    = 1'b1;
            end else begin
                n_ctl.face = cmfs_pkg::FACE_NEG_Y;
            end
        end else begin
            if (!i_z[COMP_BITS-1]) begin
                n_ctl.face = cmfs_pkg::FACE_POS_Z;
            end else begin
                n_ctl.face = cmfs_pkg::FACE_NEG_Z;
                n_sub_u    = 1'b1;
            end
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_m     <= n_m;
            r_cu    <= n_cu;
            r_cv    <= n_cv;
            r_sub_u <= n_sub_u;
            r_sub_v <= n_sub_v;
            r_ctl   <= n_ctl;
        end
    end

    assign o_valid = r_valid;
    assign o_m     = r_m;
    assign o_cu    = r_cu;
    assign o_cv    = r_cv;
    assign o_sub_u = r_sub_u;
    assign o_sub_v = r_sub_v;
    assign o_ctl   = r_ctl;

endmodule

// ===== hw/rtl/cmfs_numer.sv =====
// ----------------------------------------------------------------------------
// cmfs_numer: numerator and divisor stage
// Forms m +/- c for both coordinates, the divisor 2m and the saturation flags.
// ----------------------------------------------------------------------------
module cmfs_numer #(
    parameter int COMP_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic        [COMP_BITS-1:0] i_m,
    input  logic signed [COMP_BITS-1:0] i_cu,
    input  logic signed [COMP_BITS-1:0] i_cv,
    input  logic                        i_sub_u,
    input  logic                        i_sub_v,
    input  cmfs_pkg::t_ctl              i_ctl,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic        [COMP_BITS:0]   o_nu,
    output logic        [COMP_BITS:0]   o_nv,
    output logic        [COMP_BITS:0]   o_d,
    output logic                        o_sat_u,
    output logic                        o_sat_v,
    output cmfs_pkg::t_ctl              o_ctl
);

    localparam int NUM_W = COMP_BITS + 1;

    logic                      r_valid;
    logic        [NUM_W-1:0]   r_nu, r_nv, r_d, n_nu, n_nv, n_d;
    logic                      r_sat_u, r_sat_v;
    cmfs_pkg::t_ctl            r_ctl;
    logic signed [COMP_BITS+1:0] w_m_s, w_cu_s, w_cv_s, w_su, w_sv;
    logic                      w_load;

    always_comb begin
        w_m_s  = signed'({2'b00, i_m});
        w_cu_s = signed'({{2{i_cu[COMP_BITS-1]}}, i_cu});
        w_cv_s = signed'({{2{i_cv[COMP_BITS-1]}}, i_cv});
        w_su   = i_sub_u ? (w_m_s - w_cu_s) : (w_m_s + w_cu_s);
        w_sv   = i_sub_v ? (w_m_s - w_cv_s) : (w_m_s + w_cv_s);
        // both sums lie in 0..2m
        n_nu   = w_su[NUM_W-1:0];
        n_nv   = w_sv[NUM_W-1:0];
        // a zero vector divides by one so the quotient comes out zero
        n_d    = i_ctl.zero ? NUM_W'(1) : {i_m, 1'b0};
    end

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_nu    <= n_nu;
            r_nv    <= n_nv;
            r_d     <= n_d;
            r_sat_u <= (n_nu == n_d);
            r_sat_v <= (n_nv == n_d);
            r_ctl   <= i_ctl;
        end
    end

    assign o_valid = r_valid;
    assign o_nu    = r_nu;
    assign o_nv    = r_nv;
    assign o_d     = r_d;
    assign o_sat_u = r_sat_u;
    assign o_sat_v = r_sat_v;
    assign o_ctl   = r_ctl;

endmodule

// ===== hw/rtl/cmfs_div_step.sv =====
// ----------------------------------------------------------------------------
// cmfs_div_step: one restoring division step for the u and v lanes
// Shift the partial remainder, compare against 2m, subtract, shift in a bit.
// ----------------------------------------------------------------------------
module cmfs_div_step #(
    parameter int COMP_BITS = 16,
    parameter int UV_BITS   = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [COMP_BITS+1:0]   i_ru,
    input  logic [COMP_BITS+1:0]   i_rv,
    input  logic [UV_BITS-1:0]     i_qu,
    input  logic [UV_BITS-1:0]     i_qv,
    input  logic                   i_sat_u,
    input  logic                   i_sat_v,
    input  logic [COMP_BITS:0]     i_d,
    input  cmfs_pkg::t_ctl         i_ctl,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [COMP_BITS+1:0]   o_ru,
    output logic [COMP_BITS+1:0]   o_rv,
    output logic [UV_BITS-1:0]     o_qu,
    output logic [UV_BITS-1:0]     o_qv,
    output logic                   o_sat_u,
    output logic                   o_sat_v,
    output logic [COMP_BITS:0]     o_d,
    output cmfs_pkg::t_ctl         o_ctl
);

    localparam int REM_W = COMP_BITS + 2;

    logic                 r_valid;
    logic [REM_W-1:0]     r_ru, r_rv, n_ru, n_rv;
    logic [UV_BITS-1:0]   r_qu, r_qv, n_qu, n_qv;
    logic                 r_sat_u, r_sat_v;
    logic [COMP_BITS:0]   r_d;
    cmfs_pkg::t_ctl       r_ctl;
    logic [REM_W-1:0]     w_su, w_sv, w_dx;
    logic                 w_ge_u, w_ge_v, w_load;

    always_comb begin
        w_dx   = {1'b0, i_d};
        w_su   = {i_ru[REM_W-2:0], 1'b0};
        w_sv   = {i_rv[REM_W-2:0], 1'b0};
        w_ge_u = (w_su >= w_dx);
        w_ge_v = (w_sv >= w_dx);
        n_ru   = w_ge_u ? (w_su - w_dx) : w_su;
        n_rv   = w_ge_v ? (w_sv - w_dx) : w_sv;
        // a saturated lane forces ones into every quotient bit
        n_qu   = {i_qu[UV_BITS-2:0], w_ge_u | i_sat_u};
        n_qv   = {i_qv[UV_BITS-2:0], w_ge_v | i_sat_v};
    end

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ru    <= n_ru;
            r_rv    <= n_rv;
            r_qu    <= n_qu;
            r_qv    <= n_qv;
            r_sat_u <= i_sat_u;
            r_sat_v <= i_sat_v;
            r_d     <= i_d;
            r_ctl   <= i_ctl;
        end
    end

    assign o_valid = r_valid;
    assign o_ru    = r_ru;
    assign o_rv    = r_rv;
    assign o_qu    = r_qu;
    assign o_qv    = r_qv;
    assign o_sat_u = r_sat_u;
    assign o_sat_v = r_sat_v;
    assign o_d     = r_d;
    assign o_ctl   = r_ctl;

endmodule

// ===== hw/rtl/cube_map_face_select.sv =====
// Depth: magnitude, select and numerator stages, then the UV_BITS-stage
//   restoring divider (one quotient bit per stage, u and v in parallel lanes).
// Throughput: one transaction per cycle while the output is not stalled.
// Stalls hold each stage in place; empty stages still accept, so bubbles close.
// Reset: synchronous, active low; clears every stage's valid bit, drops any
//   transaction in flight. Data registers are not reset.
// ----------------------------------------------------------------------------
// cube_map_face_select: cube map face selection with face coordinates
// Picks the major-axis face of a signed direction and computes u, v as
// (m +/- c) / (2m) in unsigned fixed point, saturating 1.0 to all ones.
// ----------------------------------------------------------------------------
module cube_map_face_select #(
    parameter int COMP_BITS = 16,
    parameter int UV_BITS   = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [COMP_BITS-1:0] i_dir_x,
    input  logic signed [COMP_BITS-1:0] i_dir_y,
    input  logic signed [COMP_BITS-1:0] i_dir_z,
    // result channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [cmfs_pkg::FACE_BITS-1:0] o_face,
    output logic [UV_BITS-1:0]          o_tex_u,
    output logic [UV_BITS-1:0]          o_tex_v,
    output logic                        o_zero_dir
);

    localparam int REM_W = COMP_BITS + 2;
    localparam int NUM_W = COMP_BITS + 1;

    // stage 1 -> stage 2
    logic                        w_mag_valid, w_mag_ready;
    logic signed [COMP_BITS-1:0] w_x, w_y, w_z;
    logic        [COMP_BITS-1:0] w_ax, w_ay, w_az;

    // stage 2 -> stage 3
    logic                        w_sel_valid, w_sel_ready;
    logic        [COMP_BITS-1:0] w_m;
    logic signed [COMP_BITS-1:0] w_cu, w_cv;
    logic                        w_sub_u, w_sub_v;
    cmfs_pkg::t_ctl              w_sel_ctl;

    // stage 3 -> divider
    logic [NUM_W-1:0]            w_nu, w_nv;

    // divider pipe: index k feeds step k, index k+1 is its output
    logic                        s_valid [0:UV_BITS];
    logic                        s_ready [0:UV_BITS];
    logic [REM_W-1:0]            s_ru    [0:UV_BITS];
    logic [REM_W-1:0]            s_rv    [0:UV_BITS];
    logic [UV_BITS-1:0]          s_qu    [0:UV_BITS];
    logic [UV_BITS-1:0]          s_qv    [0:UV_BITS];
    logic                        s_sat_u [0:UV_BITS];
    logic                        s_sat_v [0:UV_BITS];
    logic [NUM_W-1:0]            s_d     [0:UV_BITS];
    cmfs_pkg::t_ctl              s_ctl   [0:UV_BITS];

    // stage 1: magnitudes
    cmfs_mag #(
        .COMP_BITS (COMP_BITS)
    ) u_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_x     (i_dir_x),
        .i_y     (i_dir_y),
        .i_z     (i_dir_z),
        .o_valid (w_mag_valid),
        .i_ready (w_mag_ready),
        .o_x     (w_x),
        .o_y     (w_y),
        .o_z     (w_z),
        .o_ax    (w_ax),
        .o_ay    (w_ay),
        .o_az    (w_az)
    );

    // stage 2: major axis, face, coordinate sources
    cmfs_select #(
        .COMP_BITS (COMP_BITS)
    ) u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mag_valid),
        .o_ready (w_mag_ready),
        .i_x     (w_x),
        .i_y     (w_y),
        .i_z     (w_z),
        .i_ax    (w_ax),
        .i_ay    (w_ay),
        .i_az    (w_az),
        .o_valid (w_sel_valid),
        .i_ready (w_sel_ready),
        .o_m     (w_m),
        .o_cu    (w_cu),
        .o_cv    (w_cv),
        .o_sub_u (w_sub_u),
        .o_sub_v (w_sub_v),
        .o_ctl   (w_sel_ctl)
    );

    // stage 3: numerators, divisor 2m, saturation when the numerator is 2m
    cmfs_numer #(
        .COMP_BITS (COMP_BITS)
    ) u_numer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sel_valid),
        .o_ready (w_sel_ready),
        .i_m     (w_m),
        .i_cu    (w_cu),
        .i_cv    (w_cv),
        .i_sub_u (w_sub_u),
        .i_sub_v (w_sub_v),
        .i_ctl   (w_sel_ctl),
        .o_valid (s_valid[0]),
        .i_ready (s_ready[0]),
        .o_nu    (w_nu),
        .o_nv    (w_nv),
        .o_d     (s_d[0]),
        .o_sat_u (s_sat_u[0]),
        .o_sat_v (s_sat_v[0]),
        .o_ctl   (s_ctl[0])
    );

    // seed the divider: numerator is the starting remainder, quotient empty
    assign s_ru[0] = {1'b0, w_nu};
    assign s_rv[0] = {1'b0, w_nv};
    assign s_qu[0] = '0;
    assign s_qv[0] = '0;

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < UV_BITS; k++) begin : g_div
        cmfs_div_step #(
            .COMP_BITS (COMP_BITS),
            .UV_BITS   (UV_BITS)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[k]),
            .o_ready (s_ready[k]),
            .i_ru    (s_ru[k]),
            .i_rv    (s_rv[k]),
            .i_qu    (s_qu[k]),
            .i_qv    (s_qv[k]),
            .i_sat_u (s_sat_u[k]),
            .i_sat_v (s_sat_v[k]),
            .i_d     (s_d[k]),
            .i_ctl   (s_ctl[k]),
            .o_valid (s_valid[k+1]),
            .i_ready (s_ready[k+1]),
            .o_ru    (s_ru[k+1]),
            .o_rv    (s_rv[k+1]),
            .o_qu    (s_qu[k+1]),
            .o_qv    (s_qv[k+1]),
            .o_sat_u (s_sat_u[k+1]),
            .o_sat_v (s_sat_v[k+1]),
            .o_d     (s_d[k+1]),
            .o_ctl   (s_ctl[k+1])
        );
    end

    // the last divider step is the output register; the final remainders,
    // divisor and saturation flags are spent here
    assign s_ready[UV_BITS] = i_ready;
    assign o_valid    = s_valid[UV_BITS];
    assign o_face     = s_ctl[UV_BITS].face;
    assign o_zero_dir = s_ctl[UV_BITS].zero;
    assign o_tex_u    = s_qu[UV_BITS];
    assign o_tex_v    = s_qv[UV_BITS];

endmodule

// ===== hw/rtl/cmfs_checker.sv =====
// ----------------------------------------------------------------------------
// cmfs_checker: port-level checks for cube_map_face_select
// Watches the top-level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module cmfs_checker #(
    parameter int COMP_BITS = 16,
    parameter int UV_BITS   = 16
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [cmfs_pkg::FACE_BITS-1:0] i_face,
    input logic [UV_BITS-1:0]             i_tex_u,
    input logic [UV_BITS-1:0]             i_tex_v,
    input logic                           i_zero_dir
);

    // hold the result while the consumer stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_face)
            && $stable(i_tex_u) && $stable(i_tex_v) && $stable(i_zero_dir))
        else $error("result changed while stalled");

    // a consumer that takes results must open the whole pipe to new input
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input blocked while output drains");

    // zero direction reports the +z face with zero coordinates
    a_zero_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_zero_dir |-> i_face == cmfs_pkg::FACE_POS_Z
            && i_tex_u == '0 && i_tex_v == '0)
        else $error("zero direction result malformed");

    // drop everything in flight on reset
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind cube_map_face_select cmfs_checker #(
    .COMP_BITS (COMP_BITS),
    .UV_BITS   (UV_BITS)
) u_cmfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (o_ready),
    .i_out_valid (o_valid),
    .i_out_ready (i_ready),
    .i_face      (o_face),
    .i_tex_u     (o_tex_u),
    .i_tex_v     (o_tex_v),
    .i_zero_dir  (o_zero_dir)
);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for cube_map_face_select
// Drives signed direction vectors through the valid/ready input channel and
// checks every face/u/v/zero result, in order, against typed rows or a predictor.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  COMP_BITS      = 16;
    localparam int  UV_BITS        = 16;
    localparam real CLK_PERIOD     = 8.0;
    localparam int  RESET_CYCLES   = 11;
    localparam int  MAX_GAP        = 17;
    localparam int  RANDOM_ITEMS   = 600;
    localparam int  PAUSE_AT_ITEM  = 300;
    // Receiver holds off this long twice; the pipe is ~19 deep, so it fills.
    localparam int  HOLD_CYCLES    = 120;
    localparam int  HOLD_AT_1      = 200;
    localparam int  HOLD_AT_2      = 450;
    // Pipeline latency plus margin, waited out once nothing is pending.
    localparam int  DRAIN_CYCLES   = 3 + UV_BITS + 16;
    // Longest legal quiet stretch is the hold-off above; take it many times over.
    localparam int  WATCHDOG_LIMIT = 4000;
    localparam int  REPORT_LIMIT   = 10;
    localparam longint UV_ALL_ONES = (longint'(1) << UV_BITS) - 1;

    // One result transaction as the block presents it.
    typedef struct packed {
        cmfs_pkg::t_face    face;
        logic [UV_BITS-1:0] u;
        logic [UV_BITS-1:0] v;
        logic               zero;
    } t_face_uv;

    // Directed row: hand-typed expectation used only where typed is set.
    typedef struct {
        int       x;
        int       y;
        int       z;
        bit       typed;
        t_face_uv want;
    } t_dir_row;

    localparam int N_DIR = 24;

    t_dir_row dir_table [N_DIR] = '{
        // zero vector: flagged, +z face, u = v = 0
        '{0, 0, 0, 1'b1, '{cmfs_pkg::FACE_POS_Z, 16'd0, 16'd0, 1'b1}},
        // single-axis extremes land at the face center
        '{32767, 0, 0, 1'b1, '{cmfs_pkg::FACE_POS_X, 16'd32768, 16'd32768, 1'b0}},
        '{-32768, 0, 0, 1'b1, '{cmfs_pkg::FACE_NEG_X, 16'd32768, 16'd32768, 1'b0}},
        '{0, 32767, 0, 1'b1, '{cmfs_pkg::FACE_POS_Y, 16'd32768, 16'd32768, 1'b0}},
        '{0, -32768, 0, 1'b1, '{cmfs_pkg::FACE_NEG_Y, 16'd32768, 16'd32768, 1'b0}},
        '{0, 0, 32767, 1'b1, '{cmfs_pkg::FACE_POS_Z, 16'd32768, 16'd32768, 1'b0}},
        '{0, 0, -32768, 1'b1, '{cmfs_pkg::FACE_NEG_Z, 16'd32768, 16'd32768, 1'b0}},
        // three-way ties fall to z; a full 1.0 coordinate saturates
        '{32767, 32767, 32767, 1'b1,
          '{cmfs_pkg::FACE_POS_Z, 16'd65535, 16'd65535, 1'b0}},
        '{-32768, -32768, -32768, 1'b1,
          '{cmfs_pkg::FACE_NEG_Z, 16'd65535, 16'd0, 1'b0}},
        // x/y tie with zero z: +z face, zero counts as positive; y/z tie: -z face
        '{32767, -32767, 0, 1'b1, '{cmfs_pkg::FACE_POS_Z, 16'd65535, 16'd0, 1'b0}},
        '{32767, 32767, 0, 1'b1, '{cmfs_pkg::FACE_POS_Z, 16'd65535, 16'd65535, 1'b0}},
        '{0, -32768, -32768, 1'b1, '{cmfs_pkg::FACE_NEG_Z, 16'd32768, 16'd0, 1'b0}},
        // smallest nonzero magnitude
        '{1, 0, 0, 1'b1, '{cmfs_pkg::FACE_POS_X, 16'd32768, 16'd32768, 1'b0}},
        '{-1, 0, 0, 1'b1, '{cmfs_pkg::FACE_NEG_X, 16'd32768, 16'd32768, 1'b0}},
        // most negative y just beats max positive x: truncation, no saturation
        '{32767, -32768, 0, 1'b1,
          '{cmfs_pkg::FACE_NEG_Y, 16'd65535, 16'd32768, 1'b0}},
        // the rest go through the predictor
        '{16384, -100, 200, 1'b0, '0},
        '{-20000, 12345, -19999, 1'b0, '0},
        '{300, 30000, -29999, 1'b0, '0},
        '{-5, 7, -9, 1'b0, '0},
        '{1, -1, 1, 1'b0, '0},
        '{-32768, 32767, 1, 1'b0, '0},
        '{12345, -32767, 32767, 1'b0, '0},
        '{0, 0, -1, 1'b0, '0},
        '{-7, -32767, 32766, 1'b0, '0}
    };

    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic                           i_valid    = 1'b0;
    logic                           o_ready;
    logic signed [COMP_BITS-1:0]    i_dir_x    = '0;
    logic signed [COMP_BITS-1:0]    i_dir_y    = '0;
    logic signed [COMP_BITS-1:0]    i_dir_z    = '0;
    logic                           o_valid;
    logic                           i_ready    = 1'b0;
    logic [cmfs_pkg::FACE_BITS-1:0] o_face;
    logic [UV_BITS-1:0]             o_tex_u;
    logic [UV_BITS-1:0]             o_tex_v;
    logic                           o_zero_dir;

    t_face_uv pending_uv [$];   // results owed by the block, oldest first
    int       mismatch_cnt  = 0;
    int       results_taken = 0;
    int       idle_cycles   = 0;
    bit       tx_burst      = 1'b0;
    bit       rx_burst      = 1'b0;
    bit       rx_holding    = 1'b0;

    cube_map_face_select #(
        .COMP_BITS (COMP_BITS),
        .UV_BITS   (UV_BITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_dir_x    (i_dir_x),
        .i_dir_y    (i_dir_y),
        .i_dir_z    (i_dir_z),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_face     (o_face),
        .o_tex_u    (o_tex_u),
        .o_tex_v    (o_tex_v),
        .o_zero_dir (o_zero_dir)
    );

    always #(CLK_PERIOD / 2.0) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Truncated num / (2m) as an unsigned fraction; 1.0 clamps to all ones.
    function automatic logic [UV_BITS-1:0] face_coord(longint num, longint m);
        longint q;
        if (num < 0) begin
            num = 0;
        end
        q = (num << UV_BITS) / (2 * m);
        if (q > UV_ALL_ONES) begin
            q = UV_ALL_ONES;
        end
        return q[UV_BITS-1:0];
    endfunction

    // Major-axis face pick and per-face orientation of u, v.
    function automatic t_face_uv map_direction(logic signed [COMP_BITS-1:0] dx,
                                               logic signed [COMP_BITS-1:0] dy,
                                               logic signed [COMP_BITS-1:0] dz);
        longint   x, y, z, ax, ay, az, m;
        t_face_uv r;
        x  = dx;
        y  = dy;
        z  = dz;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        m  = ax;
        if (ay > m) m = ay;
        if (az > m) m = az;
        r.zero = 1'b0;
        if (m == 0) begin
            r = '{cmfs_pkg::FACE_POS_Z, '0, '0, 1'b1};
        end else if (ax > ay && ax > az) begin
            if (x >= 0) begin
                r.face = cmfs_pkg::FACE_POS_X;
                r.u    = face_coord(m - z, m);
            end else begin
                r.face = cmfs_pkg::FACE_NEG_X;
                r.u    = face_coord(m + z, m);
            end
            r.v = face_coord(m + y, m);
        end else if (ay > ax && ay > az) begin
            r.u = face_coord(m + x, m);
            if (y >= 0) begin
                r.face = cmfs_pkg::FACE_POS_Y;
                r.v    = face_coord(m - z, m);
            end else begin
                r.face = cmfs_pkg::FACE_NEG_Y;
                r.v    = face_coord(m + z, m);
            end
        end else begin
            // ties, and z strictly on top, land on a z face
            if (z >= 0) begin
                r.face = cmfs_pkg::FACE_POS_Z;
                r.u    = face_coord(m + x, m);
            end else begin
                r.face = cmfs_pkg::FACE_NEG_Z;
                r.u    = face_coord(m - x, m);
            end
            r.v = face_coord(m + y, m);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic int random_sign(int a);
        return ($urandom_range(0, 1) != 0) ? -a : a;
    endfunction

    // Mix of raw noise, small vectors, a dominant axis, ties and extremes.
    task automatic pick_direction(output int x, output int y, output int z);
        int c [3];
        int m;
        int k;
        k = $urandom_range(0, 2);
        case ($urandom_range(0, 5))
            0: begin
                foreach (c[i]) c[i] = int'($urandom_range(0, 65535)) - 32768;
            end
            1: begin
                foreach (c[i]) c[i] = int'($urandom_range(0, 16)) - 8;
            end
            2: begin
                // one axis clearly on top, the others anywhere below it
                m = $urandom_range(1, 32768);
                foreach (c[i]) c[i] = random_sign($urandom_range(0, m - 1));
                c[k] = random_sign(m);
            end
            3: begin
                // at least two magnitudes equal; exercises the tie fall-through
                m = $urandom_range(0, 32768);
                foreach (c[i]) c[i] = random_sign(m);
                c[k] = random_sign($urandom_range(0, m));
            end
            4: begin
                foreach (c[i]) begin
                    case ($urandom_range(0, 5))
                        0:       c[i] = -32768;
                        1:       c[i] = 32767;
                        2:       c[i] = -1;
                        3:       c[i] = 0;
                        4:       c[i] = 1;
                        default: c[i] = int'($urandom_range(0, 65535)) - 32768;
                    endcase
                end
            end
            default: begin
                // zero vector or a lone nonzero axis
                c = '{0, 0, 0};
                if ($urandom_range(0, 1) != 0) begin
                    c[k] = int'($urandom_range(0, 65535)) - 32768;
                end
            end
        endcase
        x = c[0];
        y = c[1];
        z = c[2];
    endtask

    // Offer one direction after a random gap; book its result on acceptance.
    task automatic offer_direction(logic signed [COMP_BITS-1:0] x,
                                   logic signed [COMP_BITS-1:0] y,
                                   logic signed [COMP_BITS-1:0] z,
                                   bit typed, t_face_uv typed_want);
        int       gap;
        t_face_uv booked;
        gap = (tx_burst || rx_holding) ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_dir_x <= x;
        i_dir_y <= y;
        i_dir_z <= z;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        booked     = typed ? typed_want : map_direction(x, y, z);
        pending_uv = {pending_uv, booked};
    endtask

    // Drop valid and hold until every booked result is back.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_uv.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int x, y, z;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_table[i]) begin
            offer_direction(COMP_BITS'(dir_table[i].x), COMP_BITS'(dir_table[i].y),
                            COMP_BITS'(dir_table[i].z),
                            dir_table[i].typed, dir_table[i].want);
        end
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // alternate between idle-prone and back-to-back stretches
            if ($urandom_range(0, 39) == 0) begin
                tx_burst = ~tx_burst;
            end
            if (n == PAUSE_AT_ITEM) begin
                wait_drained();
            end
            pick_direction(x, y, z);
            offer_direction(COMP_BITS'(x), COMP_BITS'(y), COMP_BITS'(z), 1'b0, '0);
        end
        i_valid <= 1'b0;

        while (pending_uv.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_uv.size() == 0) begin
            $display("cube_map_face_select verification clean");
        end else begin
            $display("cube_map_face_select verification failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random stalls, two long hold-offs, in-order check
    // ------------------------------------------------------------------

    task automatic check_result();
        t_face_uv want;
        t_face_uv got;
        got = '{cmfs_pkg::t_face'(o_face), o_tex_u, o_tex_v, o_zero_dir};
        if (pending_uv.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_LIMIT) begin
                $display("[%0t] unexpected result: face=%0d u=%0d v=%0d zero=%0b",
                         $realtime, o_face, o_tex_u, o_tex_v, o_zero_dir);
            end
        end else begin
            want = pending_uv.pop_front();
            if (got !== want) begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_LIMIT) begin
                    $display("[%0t] result %0d: face exp %0d got %0d, u exp %0d got %0d,",
                             $realtime, results_taken, want.face, o_face, want.u, o_tex_u);
                    $display("    v exp %0d got %0d, zero exp %0b got %0b",
                             want.v, o_tex_v, want.zero, o_zero_dir);
                end
            end
        end
    endtask

    initial begin
        int stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if ($urandom_range(0, 31) == 0) begin
                rx_burst = ~rx_burst;
            end
            if (results_taken == HOLD_AT_1 || results_taken == HOLD_AT_2) begin
                // long hold-off while the sender keeps pushing: fill the pipe
                stall      = HOLD_CYCLES;
                rx_holding = 1'b1;
            end else begin
                stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rx_holding = 1'b0;
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
            check_result();
            results_taken++;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if neither channel moves for too long
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] no transaction for %0d cycles", $realtime, idle_cycles);
            $display("cube_map_face_select verification failed");
            $finish;
        end
    end

endmodule
